### rtl/core/sgrw_pkg.sv
`timescale 1ns / 1ps
package sgrw_pkg;

   localparam int WINDOW_SLOTS = 32;
   localparam int MAX_SHARDS   = 16;
   localparam int SLOT_W       = $clog2(WINDOW_SLOTS);

   localparam logic [7:0] KIND_DATA = 8'd1;
   localparam logic [7:0] KIND_END  = 8'd2;

   localparam logic [7:0] CSR_EXPECTED_SHARDS = 8'd0;
   localparam logic [7:0] CSR_MAX_BLOCK_LEN   = 8'd1;
   localparam logic [7:0] CSR_PAYLOAD_SIZE    = 8'd2;
   localparam logic [7:0] CSR_BEST_EFFORT     = 8'd3;

   typedef enum logic [3:0] {
      OC_ACCEPTED  = 4'd0,
      OC_MALFORMED = 4'd1,
      OC_LATE      = 4'd2,
      OC_DUPLICATE = 4'd3,
      OC_NO_SLOT   = 4'd4,
      OC_END       = 4'd5,
      OC_COMPLETE  = 4'd6,
      OC_PARTIAL   = 4'd7,
      OC_MISSING   = 4'd8,
      OC_DONE      = 4'd9,
      OC_IGNORED   = 4'd10
   } outcome_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_REQ,
      SEL_ACC,
      SEL_REL,
      SEL_NEXT,
      SEL_ENDC
   } sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MATCH,
      ST_SEL,
      ST_EVAL,
      ST_DONECHK,
      ST_FLCHK,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      P_DATA,
      P_CHAIN,
      P_FLUSH
   } purpose_type;

   typedef struct packed {
      logic        mode;
      logic        header_ok;
      logic        length_ok;
      logic [7:0]  datagram_kind;
      logic [31:0] flow_number;
      logic [63:0] block_number;
      logic [15:0] shard_number;
      logic [15:0] shard_total;
      logic [15:0] block_len;
      logic [15:0] payload_bytes;
      logic [63:0] begin_time;
      logic [63:0] end_time;
   } req_type;

   typedef struct packed {
      logic [3:0]  outcome;
      logic [4:0]  slot_index;
      logic [63:0] out_block;
      logic [15:0] shard_mask;
      logic [15:0] out_len;
      logic [63:0] out_begin;
      logic [63:0] out_end;
      logic        timing_good;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] mask;
      logic [15:0] len;
      logic [63:0] begin_t;
      logic [63:0] finish_t;
      logic        timing;
   } entry_type;

   typedef struct packed {
      logic        load_req;
      logic        key_next;
      logic        do_match;
      logic        do_sel;
      logic        alloc;
      logic        update;
      logic        release_slot;
      logic        inc_due;
      logic        set_end;
      logic        set_finished;
      logic        push;
      logic        emit_last;
      outcome_type outcome;
      sel_type     sel;
   } cmd_type;

   typedef struct packed {
      logic finished;
      logic mode;
      logic hok;
      logic is_end;
      logic end_bad;
      logic data_bad;
      logic late;
      logic flush_ok;
      logic due_lt_end;
      logic hit;
      logic free_ok;
      logic differ;
      logic dup;
      logic complete;
      logic done_now;
   } stat_type;

endpackage

### rtl/core/sgrw_datapath.sv
`timescale 1ns / 1ps
module sgrw_datapath
   import sgrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   input  logic        csr_valid,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   function automatic logic [SLOT_W-1:0] first_set(input logic [WINDOW_SLOTS-1:0] v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) idx = SLOT_W'(i);
      end
      return idx;
   endfunction

   logic [4:0]  es_ff;
   logic [15:0] max_len_ff;
   logic [15:0] psize_ff;
   logic        be_ff;

   req_type     req_ff;
   logic [WINDOW_SLOTS-1:0] busy_ff;
   logic [63:0] block_ff [WINDOW_SLOTS];
   entry_type   mem [WINDOW_SLOTS];
   entry_type   rd_ff;
   logic [WINDOW_SLOTS-1:0] match_ff;
   logic        hit_ff;
   logic [SLOT_W-1:0] hit_idx_ff;
   logic        free_ok_ff;
   logic [SLOT_W-1:0] free_idx_ff;
   logic [63:0] next_due_ff;
   logic        end_known_ff;
   logic [63:0] end_count_ff;
   logic        finished_ff;
   logic        pend_v_ff;
   rsp_type     pend_ff;
   logic        out_v_ff;
   rsp_type     out_ff;
   rsp_type     out_in;

   logic [63:0] key;
   logic [15:0] bit_in;
   logic [16:0] need;
   entry_type   new_entry;
   entry_type   upd_entry;
   rsp_type     new_rsp;
   logic [SLOT_W-1:0] acc_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff      <= 5'd16;
         max_len_ff <= 16'd4096;
         psize_ff   <= 16'd1024;
         be_ff      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EXPECTED_SHARDS: es_ff      <= csr_wdata[4:0];
            CSR_MAX_BLOCK_LEN:   max_len_ff <= csr_wdata;
            CSR_PAYLOAD_SIZE:    psize_ff   <= csr_wdata;
            CSR_BEST_EFFORT:     be_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign key    = cmd.key_next ? next_due_ff : req_ff.block_number;
   assign bit_in = 16'd1 << req_ff.shard_number[3:0];
   assign need   = (17'd1 << es_ff) - 17'd1;
   assign acc_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      new_entry.mask     = bit_in;
      new_entry.len      = req_ff.block_len;
      new_entry.begin_t  = req_ff.begin_time;
      new_entry.finish_t = req_ff.end_time;
      new_entry.timing   = (req_ff.begin_time != 64'd0) &&
                           (req_ff.end_time >= req_ff.begin_time);
      upd_entry      = rd_ff;
      upd_entry.mask = rd_ff.mask | bit_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      if (cmd.do_match) begin
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            match_ff[i] <= busy_ff[i] && (block_ff[i] == key);
         end
      end
      if (cmd.do_sel) begin
         hit_ff      <= |match_ff;
         hit_idx_ff  <= first_set(match_ff);
         free_ok_ff  <= ~&busy_ff;
         free_idx_ff <= first_set(~busy_ff);
         rd_ff       <= mem[first_set(match_ff)];
      end
      if (cmd.alloc) begin
         mem[free_idx_ff]      <= new_entry;
         block_ff[free_idx_ff] <= req_ff.block_number;
      end else if (cmd.update) begin
         mem[hit_idx_ff] <= upd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         next_due_ff  <= '0;
         end_known_ff <= 1'b0;
         end_count_ff <= '0;
         finished_ff  <= 1'b0;
      end else begin
         if (cmd.alloc) busy_ff[free_idx_ff] <= 1'b1;
         if (cmd.release_slot) busy_ff[hit_idx_ff] <= 1'b0;
         if (cmd.inc_due) next_due_ff <= next_due_ff + 64'd1;
         if (cmd.set_end) begin
            end_known_ff <= 1'b1;
            end_count_ff <= req_ff.block_number;
         end
         if (cmd.set_finished) finished_ff <= 1'b1;
      end
   end

   always_comb begin
      new_rsp         = '0;
      new_rsp.outcome = cmd.outcome;
      unique case (cmd.sel)
         SEL_ZERO: ;
         SEL_REQ:  new_rsp.out_block = req_ff.block_number;
         SEL_ACC: begin
            new_rsp.out_block  = req_ff.block_number;
            new_rsp.slot_index = 5'(acc_idx);
         end
         SEL_REL: begin
            new_rsp.slot_index  = 5'(hit_idx_ff);
            new_rsp.out_block   = next_due_ff;
            new_rsp.shard_mask  = rd_ff.mask;
            new_rsp.out_len     = rd_ff.len;
            new_rsp.out_begin   = rd_ff.begin_t;
            new_rsp.out_end     = rd_ff.finish_t;
            new_rsp.timing_good = rd_ff.timing;
         end
         SEL_NEXT: new_rsp.out_block = next_due_ff;
         SEL_ENDC: new_rsp.out_block = end_count_ff;
         default: ;
      endcase
   end

   always_comb begin
      out_in      = pend_ff;
      out_in.last = cmd.emit_last;
   end

   // A result waits in the pending register until the next push or the final step, so that its last flag is known.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= (cmd.push && pend_v_ff) || (cmd.emit_last && pend_v_ff);
         if (cmd.push) pend_v_ff <= 1'b1;
         else if (cmd.emit_last) pend_v_ff <= 1'b0;
      end
      if (cmd.push) pend_ff <= new_rsp;
      if (cmd.push || cmd.emit_last) out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

   always_comb begin
      stat.finished   = finished_ff;
      stat.mode       = req_ff.mode;
      stat.hok        = req_ff.header_ok;
      stat.is_end     = req_ff.datagram_kind == KIND_END;
      stat.end_bad    = (req_ff.flow_number != 32'd0) ||
                        (req_ff.shard_total != {11'd0, es_ff}) ||
                        (req_ff.payload_bytes != 16'd0) ||
                        (end_known_ff && (req_ff.block_number != end_count_ff));
      stat.data_bad   = (req_ff.datagram_kind != KIND_DATA) ||
                        (req_ff.flow_number != 32'd0) ||
                        (req_ff.shard_total != {11'd0, es_ff}) ||
                        (req_ff.shard_number >= {11'd0, es_ff}) ||
                        (req_ff.shard_number >= 16'(MAX_SHARDS)) ||
                        (req_ff.block_len == 16'd0) ||
                        (req_ff.block_len > max_len_ff) ||
                        (req_ff.payload_bytes != psize_ff) ||
                        !req_ff.length_ok;
      stat.late       = req_ff.block_number < next_due_ff;
      stat.flush_ok   = be_ff && end_known_ff;
      stat.due_lt_end = next_due_ff < end_count_ff;
      stat.hit        = hit_ff;
      stat.free_ok    = free_ok_ff;
      stat.differ     = (rd_ff.len != req_ff.block_len) ||
                        (rd_ff.begin_t != req_ff.begin_time) ||
                        (rd_ff.finish_t != req_ff.end_time);
      stat.dup        = (rd_ff.mask & bit_in) != 16'd0;
      stat.complete   = (es_ff != 5'd0) && (es_ff <= 5'd16) && (rd_ff.mask == need[15:0]);
      stat.done_now   = end_known_ff && (next_due_ff == end_count_ff);
   end

   a_push_last_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.emit_last)) else $error("push and last issued together");
   a_release_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.release_slot |-> hit_ff) else $error("release without a matching slot");
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (free_ok_ff && !busy_ff[free_idx_ff])) else $error("alloc of busy slot");
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (!pend_v_ff && out_ff.last)) else $error("pending result kept");

endmodule

### rtl/core/sgrw_ctrl.sv
`timescale 1ns / 1ps
module sgrw_ctrl
   import sgrw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type   state_ff, state_in;
   purpose_type purpose_ff, purpose_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         purpose_ff <= P_DATA;
      end else begin
         state_ff   <= state_in;
         purpose_ff <= purpose_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      purpose_in = purpose_ff;
      cmd        = '0;
      cmd.outcome = OC_IGNORED;
      cmd.sel     = SEL_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FIN;
            priority if (stat.finished) begin
               cmd.push = 1'b1;
            end else if (stat.mode) begin
               if (!stat.flush_ok) begin
                  cmd.push = 1'b1;
               end else if (stat.due_lt_end) begin
                  purpose_in = P_FLUSH;
                  state_in   = ST_MATCH;
               end else begin
                  cmd.push         = 1'b1;
                  cmd.outcome      = OC_DONE;
                  cmd.sel          = SEL_ENDC;
                  cmd.set_finished = 1'b1;
               end
            end else if (!stat.hok) begin
               cmd.push    = 1'b1;
               cmd.outcome = OC_MALFORMED;
               cmd.sel     = SEL_REQ;
            end else if (stat.is_end) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_REQ;
               if (stat.end_bad) begin
                  cmd.outcome = OC_MALFORMED;
               end else begin
                  cmd.outcome = OC_END;
                  cmd.set_end = 1'b1;
                  state_in    = ST_DONECHK;
               end
            end else if (stat.data_bad) begin
               cmd.push    = 1'b1;
               cmd.outcome = OC_MALFORMED;
               cmd.sel     = SEL_REQ;
            end else if (stat.late) begin
               cmd.push    = 1'b1;
               cmd.outcome = OC_LATE;
               cmd.sel     = SEL_REQ;
            end else begin
               purpose_in = P_DATA;
               state_in   = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.key_next = purpose_ff != P_DATA;
            cmd.do_match = 1'b1;
            state_in     = ST_SEL;
         end
         ST_SEL: begin
            cmd.do_sel = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (purpose_ff)
               P_DATA: begin
                  cmd.push = 1'b1;
                  cmd.sel  = SEL_REQ;
                  state_in = ST_FIN;
                  priority if (!stat.hit && !stat.free_ok) begin
                     cmd.outcome = OC_NO_SLOT;
                  end else if (!stat.hit) begin
                     cmd.alloc   = 1'b1;
                     cmd.outcome = OC_ACCEPTED;
                     cmd.sel     = SEL_ACC;
                     purpose_in  = P_CHAIN;
                     state_in    = ST_MATCH;
                  end else if (stat.differ) begin
                     cmd.outcome = OC_MALFORMED;
                  end else if (stat.dup) begin
                     cmd.outcome = OC_DUPLICATE;
                  end else begin
                     cmd.update  = 1'b1;
                     cmd.outcome = OC_ACCEPTED;
                     cmd.sel     = SEL_ACC;
                     purpose_in  = P_CHAIN;
                     state_in    = ST_MATCH;
                  end
               end
               P_CHAIN: begin
                  if (stat.hit && stat.complete) begin
                     cmd.push         = 1'b1;
                     cmd.outcome      = OC_COMPLETE;
                     cmd.sel          = SEL_REL;
                     cmd.release_slot = 1'b1;
                     cmd.inc_due      = 1'b1;
                     state_in         = ST_MATCH;
                  end else begin
                     state_in = ST_DONECHK;
                  end
               end
               P_FLUSH: begin
                  cmd.push    = 1'b1;
                  cmd.inc_due = 1'b1;
                  if (stat.hit) begin
                     cmd.outcome      = stat.complete ? OC_COMPLETE : OC_PARTIAL;
                     cmd.sel          = SEL_REL;
                     cmd.release_slot = 1'b1;
                  end else begin
                     cmd.outcome = OC_MISSING;
                     cmd.sel     = SEL_NEXT;
                  end
                  state_in = ST_FLCHK;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_DONECHK: begin
            if (stat.done_now) begin
               cmd.push         = 1'b1;
               cmd.outcome      = OC_DONE;
               cmd.sel          = SEL_ENDC;
               cmd.set_finished = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FLCHK: begin
            if (!stat.due_lt_end) begin
               cmd.push         = 1'b1;
               cmd.outcome      = OC_DONE;
               cmd.sel          = SEL_ENDC;
               cmd.set_finished = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.emit_last = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (state_ff == ST_IDLE)) else $error("request loaded while busy");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (state_ff == ST_IDLE)) else $error("finish did not return");
   a_sel_after_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL) |-> ($past(state_ff) == ST_MATCH)) else $error("lookup out of order");

endmodule

### rtl/core/shard_group_reassembly_window_unit.sv
`timescale 1ns / 1ps
// Shard group reassembly window.
// Requests enter on req (header, end marker or flush step) when start is high
// and busy is low. Results leave on rsp, one per cycle where rsp_valid is high;
// the final result of a request carries rsp.last. The receiver cannot stall,
// so every result is presented for exactly one cycle.
// Registers are written on the csr channel (csr_ready is always high) while
// no request is in flight; this binds the user, the block does not enforce it.
// A request settled at decode has a single result. A data header runs one slot
// lookup (match, select, read); an accepted one runs a further lookup for the
// head block plus one per group released in order. A flush step that is not
// settled at decode runs one lookup of the due block. These steps are sequenced
// around the single slot store read port.
// Reset clears the slot busy bits, the block order counters and the end
// state, and restores the register defaults; slot contents are left as they
// are and are only used for busy slots.
module shard_group_reassembly_window_unit
   import sgrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sgrw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sgrw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

### verif/shard_group_reassembly_window_unit_test.sv
`timescale 1ns / 1ps
module shard_group_reassembly_window_unit_test;
   import sgrw_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req = '0;
   logic        rsp_valid;
   rsp_type     rsp;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   shard_group_reassembly_window_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   req_type pending_requests[$];
   rsp_type expected_results[$];
   int      mismatch_count = 0;
   int      send_idle_pct = 32;

   // Register copies used by the window predictor and the request generator.
   logic [4:0]  cfg_shards = 5'd16;
   logic [15:0] cfg_max_len = 16'd4096;
   logic [15:0] cfg_payload = 16'd1024;
   logic        cfg_best = 1'b0;

   // Predicted window state.
   logic        grp_busy [WINDOW_SLOTS] = '{default: 1'b0};
   logic [63:0] grp_block [WINDOW_SLOTS];
   logic [15:0] grp_mask [WINDOW_SLOTS];
   logic [15:0] grp_len [WINDOW_SLOTS];
   logic [63:0] grp_begin [WINDOW_SLOTS];
   logic [63:0] grp_finish [WINDOW_SLOTS];
   logic        grp_timing [WINDOW_SLOTS];
   logic [63:0] due_block = '0;
   logic        end_noted = 1'b0;
   logic [63:0] end_total = '0;
   logic        transfer_over = 1'b0;

   // Generator bookkeeping: next fresh block and the bound below which blocks are late.
   logic [63:0] gen_next = '0;
   logic [63:0] gen_released = '0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic rsp_type plain_rsp(input outcome_type oc, input logic [63:0] blk);
      rsp_type r;
      r = '0;
      r.outcome = oc;
      r.out_block = blk;
      return r;
   endfunction

   function automatic rsp_type group_rsp(input outcome_type oc, input int s);
      rsp_type r;
      r = '0;
      r.outcome = oc;
      r.slot_index = s[4:0];
      r.out_block = grp_block[s];
      r.shard_mask = grp_mask[s];
      r.out_len = grp_len[s];
      r.out_begin = grp_begin[s];
      r.out_end = grp_finish[s];
      r.timing_good = grp_timing[s];
      return r;
   endfunction

   function automatic int lookup_slot(input logic [63:0] blk);
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         if (grp_busy[i] && grp_block[i] == blk) return i;
      end
      return -1;
   endfunction

   function automatic logic grp_full(input int s);
      if (cfg_shards == 0 || cfg_shards > 16) return 1'b0;
      return {16'd0, grp_mask[s]} == (32'd1 << cfg_shards) - 32'd1;
   endfunction

   task automatic predict_reassembly(input req_type r);
      rsp_type outs[$];
      rsp_type tail;
      int      s;
      int      h;
      logic [15:0] bit_m;
      if (transfer_over) begin
         outs.push_back(plain_rsp(OC_IGNORED, '0));
      end else if (r.mode) begin
         if (!cfg_best || !end_noted) begin
            outs.push_back(plain_rsp(OC_IGNORED, '0));
         end else begin
            if (due_block < end_total) begin
               s = lookup_slot(due_block);
               if (s < 0) begin
                  outs.push_back(plain_rsp(OC_MISSING, due_block));
               end else begin
                  outs.push_back(group_rsp(grp_full(s) ? OC_COMPLETE : OC_PARTIAL, s));
                  grp_busy[s] = 1'b0;
               end
               due_block++;
            end
            if (due_block >= end_total) begin
               transfer_over = 1'b1;
               outs.push_back(plain_rsp(OC_DONE, end_total));
            end
         end
      end else if (!r.header_ok) begin
         outs.push_back(plain_rsp(OC_MALFORMED, r.block_number));
      end else if (r.datagram_kind == KIND_END) begin
         if (r.flow_number != 0 || r.shard_total != {11'd0, cfg_shards} ||
             r.payload_bytes != 0 || (end_noted && r.block_number != end_total)) begin
            outs.push_back(plain_rsp(OC_MALFORMED, r.block_number));
         end else begin
            end_noted = 1'b1;
            end_total = r.block_number;
            outs.push_back(plain_rsp(OC_END, r.block_number));
            if (due_block == end_total) begin
               transfer_over = 1'b1;
               outs.push_back(plain_rsp(OC_DONE, end_total));
            end
         end
      end else if (r.datagram_kind != KIND_DATA || r.flow_number != 0 ||
                   r.shard_total != {11'd0, cfg_shards} ||
                   r.shard_number >= {11'd0, cfg_shards} || r.shard_number >= MAX_SHARDS ||
                   r.block_len == 0 || r.block_len > cfg_max_len ||
                   r.payload_bytes != cfg_payload || !r.length_ok) begin
         outs.push_back(plain_rsp(OC_MALFORMED, r.block_number));
      end else if (r.block_number < due_block) begin
         outs.push_back(plain_rsp(OC_LATE, r.block_number));
      end else begin
         s = lookup_slot(r.block_number);
         if (s < 0) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
               if (s < 0 && !grp_busy[i]) s = i;
            end
            if (s >= 0) begin
               grp_busy[s] = 1'b1;
               grp_block[s] = r.block_number;
               grp_mask[s] = '0;
               grp_len[s] = r.block_len;
               grp_begin[s] = r.begin_time;
               grp_finish[s] = r.end_time;
               grp_timing[s] = r.begin_time != 0 && r.end_time >= r.begin_time;
            end
         end
         if (s < 0) begin
            outs.push_back(plain_rsp(OC_NO_SLOT, r.block_number));
         end else if (grp_len[s] != r.block_len || grp_begin[s] != r.begin_time ||
                      grp_finish[s] != r.end_time) begin
            outs.push_back(plain_rsp(OC_MALFORMED, r.block_number));
         end else begin
            bit_m = 16'd1 << r.shard_number[3:0];
            if ((grp_mask[s] & bit_m) != 0) begin
               outs.push_back(plain_rsp(OC_DUPLICATE, r.block_number));
            end else begin
               grp_mask[s] = grp_mask[s] | bit_m;
               tail = plain_rsp(OC_ACCEPTED, r.block_number);
               tail.slot_index = s[4:0];
               outs.push_back(tail);
               // Release every complete group at the head of the block order.
               h = lookup_slot(due_block);
               while (h >= 0 && grp_full(h)) begin
                  outs.push_back(group_rsp(OC_COMPLETE, h));
                  grp_busy[h] = 1'b0;
                  due_block++;
                  h = lookup_slot(due_block);
               end
               if (end_noted && due_block == end_total) begin
                  transfer_over = 1'b1;
                  outs.push_back(plain_rsp(OC_DONE, end_total));
               end
            end
         end
      end
      tail = outs.pop_back();
      tail.last = 1'b1;
      outs.push_back(tail);
      foreach (outs[i]) expected_results.push_back(outs[i]);
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // Driver: a request stays on the port until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_reassembly(req);
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req <= pending_requests.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, outcome %0d", rsp.outcome));
         end else begin
            want = expected_results.pop_front();
            compare_field("outcome", 64'(rsp.outcome), 64'(want.outcome));
            compare_field("slot_index", 64'(rsp.slot_index), 64'(want.slot_index));
            compare_field("out_block", rsp.out_block, want.out_block);
            compare_field("shard_mask", 64'(rsp.shard_mask), 64'(want.shard_mask));
            compare_field("out_len", 64'(rsp.out_len), 64'(want.out_len));
            compare_field("out_begin", rsp.out_begin, want.out_begin);
            compare_field("out_end", rsp.out_end, want.out_end);
            compare_field("timing_good", 64'(rsp.timing_good), 64'(want.timing_good));
            compare_field("last", 64'(rsp.last), 64'(want.last));
         end
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_EXPECTED_SHARDS: cfg_shards = val[4:0];
         CSR_MAX_BLOCK_LEN:   cfg_max_len = val;
         CSR_PAYLOAD_SIZE:    cfg_payload = val;
         CSR_BEST_EFFORT:     cfg_best = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic req_type random_req();
      req_type r;
      r.mode = 1'($urandom_range(0, 1));
      r.header_ok = 1'($urandom_range(0, 1));
      r.length_ok = 1'($urandom_range(0, 1));
      r.datagram_kind = 8'($urandom);
      r.flow_number = $urandom;
      r.block_number = {$urandom, $urandom};
      r.shard_number = 16'($urandom);
      r.shard_total = 16'($urandom);
      r.block_len = 16'($urandom);
      r.payload_bytes = 16'($urandom);
      r.begin_time = {$urandom, $urandom};
      r.end_time = {$urandom, $urandom};
      return r;
   endfunction

   function automatic req_type make_hdr(input logic [63:0] blk, input int shard,
                                        input logic [15:0] blen, input logic [63:0] bt,
                                        input logic [63:0] et);
      req_type r;
      r = '0;
      r.header_ok = 1'b1;
      r.length_ok = 1'b1;
      r.datagram_kind = KIND_DATA;
      r.block_number = blk;
      r.shard_number = shard[15:0];
      r.shard_total = {11'd0, cfg_shards};
      r.block_len = blen;
      r.payload_bytes = cfg_payload;
      r.begin_time = bt;
      r.end_time = et;
      return r;
   endfunction

   function automatic req_type make_end(input logic [63:0] count);
      req_type r;
      r = '0;
      r.header_ok = 1'b1;
      r.datagram_kind = KIND_END;
      r.block_number = count;
      r.shard_total = {11'd0, cfg_shards};
      return r;
   endfunction

   function automatic req_type make_flush();
      req_type r;
      r = random_req();
      r.mode = 1'b1;
      return r;
   endfunction

   // Junk that the block must reject as malformed, so it never occupies a slot.
   task automatic push_noise();
      req_type r;
      r = random_req();
      r.mode = 1'b0;
      if ($urandom_range(0, 1)) r.header_ok = 1'b0;
      else if (r.flow_number == 0) r.flow_number = 32'd1;
      pending_requests.push_back(r);
   endtask

   // Sends nsh shards of one group in random order, with occasional duplicates,
   // conflicting group fields, late blocks and junk mixed in.
   task automatic push_group(input logic [63:0] blk, input int nsh, input logic settled);
      int          order[16];
      int          j;
      int          k;
      int          tmp;
      int          width;
      logic [15:0] blen;
      logic [63:0] bt;
      logic [63:0] et;
      req_type     r;
      width = (cfg_shards > 16) ? 16 : int'(cfg_shards);
      blen = 16'($urandom_range(1, cfg_max_len));
      bt = {$urandom, $urandom};
      et = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) bt = '0;
      for (j = 0; j < width; j++) order[j] = j;
      for (j = width - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      for (j = 0; j < nsh; j++) begin
         pending_requests.push_back(make_hdr(blk, order[j], blen, bt, et));
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: pending_requests.push_back(make_hdr(blk, order[$urandom_range(0, j)],
                                                      blen, bt, et));
               1: begin
                  r = make_hdr(blk, order[j], blen, bt, et);
                  r.end_time = r.end_time ^ (64'd1 << $urandom_range(0, 63));
                  pending_requests.push_back(r);
               end
               2: if (gen_released != 0)
                     pending_requests.push_back(make_hdr(
                        64'($urandom_range(0, 32'(gen_released) - 1)),
                        order[j], blen, bt, et));
               default: push_noise();
            endcase
         end
      end
      if (settled) gen_released = blk + 1;
   endtask

   task automatic push_random(input int count);
      int target;
      target = pending_requests.size() + count;
      while (pending_requests.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            push_noise();
         end else begin
            push_group(gen_next, (cfg_shards > 16) ? 16 : int'(cfg_shards), 1'b1);
            gen_next++;
         end
      end
   endtask

   initial begin
      req_type r;
      logic [63:0] base;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part with four shards per group.
      write_reg(CSR_EXPECTED_SHARDS, 16'd4);
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.header_ok = 1'b0;                    pending_requests.push_back(r);
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.datagram_kind = 8'hFF;               pending_requests.push_back(r);
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.flow_number = '1;                    pending_requests.push_back(r);
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.shard_total = '1;                    pending_requests.push_back(r);
      pending_requests.push_back(make_hdr(64'd1, 4, 16'd4096, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 16'hFFFF, 16'd4096, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 0, 16'd0, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 0, 16'hFFFF, '1, '0));
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.payload_bytes = '0;                  pending_requests.push_back(r);
      r = make_hdr(64'd1, 0, 16'd4096, '1, '0);
      r.length_ok = 1'b0;                    pending_requests.push_back(r);
      pending_requests.push_back(make_flush());
      r = make_end(64'd5);
      r.payload_bytes = '1;                  pending_requests.push_back(r);
      pending_requests.push_back(make_hdr(64'd1, 0, 16'd4096, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 0, 16'd4096, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 1, 16'd4095, '1, '0));
      pending_requests.push_back(make_hdr(64'd1, 1, 16'd4096, 64'd7, '0));
      for (int i = 3; i >= 0; i--)
         pending_requests.push_back(make_hdr(64'd0, i, 16'd1, '0, 64'd5));
      for (int i = 1; i < 4; i++)
         pending_requests.push_back(make_hdr(64'd1, i, 16'd4096, '1, '0));
      pending_requests.push_back(make_hdr(64'd0, 0, 16'd1, '0, 64'd5));
      gen_next = 64'd2;
      gen_released = 64'd2;
      wait_idle();

      // Single-shard groups at the widest lengths.
      write_reg(CSR_EXPECTED_SHARDS, 16'd1);
      write_reg(CSR_MAX_BLOCK_LEN, 16'hFFFF);
      write_reg(CSR_PAYLOAD_SIZE, 16'hFFFF);
      write_reg(CSR_BEST_EFFORT, 16'd0);
      push_random(90);
      wait_idle();

      send_idle_pct = 56;
      // With no shards configured every data shard is rejected.
      write_reg(CSR_EXPECTED_SHARDS, 16'd0);
      pending_requests.push_back(make_hdr(gen_next, 0, 16'd1, 64'd1, 64'd2));
      pending_requests.push_back(make_hdr(gen_next, 1, 16'd1, 64'd1, 64'd2));
      wait_idle();
      // Above sixteen shards no group completes; these are released later.
      write_reg(CSR_EXPECTED_SHARDS, 16'd17);
      write_reg(CSR_MAX_BLOCK_LEN, 16'd1);
      write_reg(CSR_PAYLOAD_SIZE, 16'd1);
      push_group(gen_next, 16, 1'b0);
      push_group(gen_next + 1, 16, 1'b0);
      gen_next = gen_next + 2;
      wait_idle();
      write_reg(CSR_EXPECTED_SHARDS, 16'd16);
      push_random(80);
      wait_idle();

      send_idle_pct = 0;
      write_reg(CSR_EXPECTED_SHARDS, 16'd2);
      write_reg(CSR_MAX_BLOCK_LEN, 16'd4096);
      write_reg(CSR_PAYLOAD_SIZE, 16'd1024);
      write_reg(CSR_BEST_EFFORT, 16'd1);
      // Leave the head block absent and fill every slot behind it.
      base = gen_next;
      pending_requests.push_back(make_flush());
      for (int i = 1; i <= WINDOW_SLOTS; i++)
         push_group(base + i, (i == 5) ? 1 : 2, 1'b0);
      pending_requests.push_back(make_hdr(base + WINDOW_SLOTS + 1, 0, 16'd9, 64'd3, 64'd4));
      r = make_end(base + WINDOW_SLOTS + 2);
      r.flow_number = 32'h8000_0000;         pending_requests.push_back(r);
      pending_requests.push_back(make_end(base + WINDOW_SLOTS + 2));
      pending_requests.push_back(make_end(base + WINDOW_SLOTS + 3));
      push_noise();
      for (int i = 0; i < WINDOW_SLOTS + 5; i++) pending_requests.push_back(make_flush());
      pending_requests.push_back(make_hdr(base, 0, 16'd9, 64'd3, 64'd4));
      pending_requests.push_back(make_end(base + WINDOW_SLOTS + 2));
      wait_idle();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/sgrw_pkg.sv
rtl/core/sgrw_datapath.sv
rtl/core/sgrw_ctrl.sv
rtl/core/shard_group_reassembly_window_unit.sv
verif/shard_group_reassembly_window_unit_test.sv
